// File: rtl/bau_pkg.sv
// ---------------------------------------------------------------------------
// bau_pkg
// Shared types and constants for the decimal-adjust unit: instruction
// codes, per-word control bundle and the adjust constants.
// ---------------------------------------------------------------------------
package bau_pkg;

    typedef enum logic [2:0] {
        MODE_DAA = 3'd0,
        MODE_DAS = 3'd1,
        MODE_AAA = 3'd2,
        MODE_AAS = 3'd3,
        MODE_AAM = 3'd4,
        MODE_AAD = 3'd5
    } t_mode;

    localparam logic [7:0]  BCD_MAX      = 8'h99;
    localparam logic [7:0]  HI_ADJ       = 8'h60;
    localparam logic [7:0]  LO_ADJ       = 8'h06;
    localparam logic [15:0] AX_ADJ       = 16'h0106;
    localparam logic [7:0]  AAA_SF_LO    = 8'h7a;
    localparam logic [7:0]  AAA_SF_HI    = 8'hf9;
    localparam logic [7:0]  AAS_SF_LIM   = 8'h85;
    localparam logic [3:0]  AAA_OF_NIB   = 4'h7;
    localparam logic [7:0]  DAS_CF_LIM   = 8'h05;
    localparam logic [3:0]  DIGIT_MAX    = 4'd9;

    // quotient bits resolved per divider slice
    localparam int unsigned DIV_SLICE    = 4;

    // control bundle that travels with each word down the pipe
    typedef struct packed {
        logic use_div;    // aam with nonzero radix: value/ah come from divider
        logic use_mul;    // aad: value = ah*base + al
        logic mask_low;   // clear high nibble of AL after flag evaluation
        logic sf_val;     // sign taken from final value
        logic zf_val;     // zero taken from final value
        logic pf_val;     // parity taken from final value
        logic cf;
        logic af;
        logic of;
        logic sf;
        logic zf;
        logic pf;
        logic de;
    } t_ctl;

    typedef struct packed {
        logic cf;
        logic af;
        logic sf;
        logic zf;
        logic pf;
        logic of;
        logic de;
    } t_flags;

endpackage

// File: rtl/bau_div_slice.sv
// ---------------------------------------------------------------------------
// bau_div_slice
// Restoring divider slice: shifts in DIV_SLICE dividend bits and
// resolves one quotient bit per step.
// ---------------------------------------------------------------------------
module bau_div_slice
    import bau_pkg::*;
(
    input  logic [7:0]           i_rem,
    input  logic [DIV_SLICE-1:0] i_bits,
    input  logic [7:0]           i_divisor,
    output logic [7:0]           o_rem,
    output logic [DIV_SLICE-1:0] o_quo
);

    always_comb begin
        logic [8:0] part;
        part  = {1'b0, i_rem};
        o_quo = '0;
        for (int k = DIV_SLICE - 1; k >= 0; k--) begin
            part = {part[7:0], i_bits[k]};
            if (part >= {1'b0, i_divisor}) begin
                part     = part - {1'b0, i_divisor};
                o_quo[k] = 1'b1;
            end
        end
        // remainder stays below the divisor, so eight bits hold it
        o_rem = part[7:0];
    end

endmodule

// File: rtl/bau_decode.sv
// ---------------------------------------------------------------------------
// bau_decode
// First stage logic: decodes the instruction and performs the byte
// adjustments for daa, das, aaa and aas; sets up aam and aad.
// ---------------------------------------------------------------------------
module bau_decode
    import bau_pkg::*;
(
    input  logic [2:0] i_mode,
    input  logic [7:0] i_al,
    input  logic [7:0] i_ah,
    input  logic [7:0] i_base,
    input  logic       i_cf,
    input  logic       i_af,
    input  logic       i_of,
    input  logic       i_sf,
    input  logic       i_zf,
    input  logic       i_pf,
    output t_ctl       o_ctl,
    output logic [7:0] o_val,
    output logic [7:0] o_ah
);

    logic        w_lo_big;
    logic        w_hi_big;
    logic [7:0]  w_daa1;
    logic [7:0]  w_das1;
    logic [7:0]  w_das2;
    logic [15:0] w_ax_add;
    logic [15:0] w_ax_sub;

    assign w_lo_big = (i_al[3:0] > DIGIT_MAX);
    assign w_hi_big = (i_al > BCD_MAX) | i_cf;
    assign w_daa1   = w_hi_big ? i_al + HI_ADJ : i_al;
    assign w_das1   = w_hi_big ? i_al - HI_ADJ : i_al;
    assign w_das2   = (w_lo_big | i_af) ? w_das1 - LO_ADJ : w_das1;
    assign w_ax_add = {i_ah, i_al} + AX_ADJ;
    assign w_ax_sub = {i_ah, i_al} - AX_ADJ;

    always_comb begin
        // default: pass everything through unchanged
        o_ctl = '{use_div: 1'b0, use_mul: 1'b0, mask_low: 1'b0,
                  sf_val: 1'b0, zf_val: 1'b0, pf_val: 1'b0,
                  cf: i_cf, af: i_af, of: i_of, sf: i_sf, zf: i_zf,
                  pf: i_pf, de: 1'b0};
        o_val = i_al;
        o_ah  = i_ah;
        case (t_mode'(i_mode))
            MODE_DAA: begin
                o_ctl.cf     = w_hi_big;
                o_ctl.af     = w_lo_big | i_af;
                o_val        = (w_lo_big | i_af) ? w_daa1 + LO_ADJ : w_daa1;
                o_ctl.sf_val = 1'b1;
                o_ctl.zf_val = 1'b1;
                o_ctl.pf_val = 1'b1;
            end
            MODE_DAS: begin
                o_ctl.cf     = w_hi_big | ((w_lo_big | i_af) & (i_al <= DAS_CF_LIM));
                o_ctl.af     = w_lo_big | i_af;
                o_ctl.of     = i_al[7] & ~w_das2[7];
                o_val        = w_das2;
                o_ctl.sf_val = 1'b1;
                o_ctl.zf_val = 1'b1;
                o_ctl.pf_val = 1'b1;
            end
            MODE_AAA: begin
                o_ctl.mask_low = 1'b1;
                o_ctl.pf_val   = 1'b1;
                o_ctl.sf       = (i_al >= AAA_SF_LO) & (i_al <= AAA_SF_HI);
                if (w_lo_big) begin
                    o_ctl.of     = (i_al[7:4] == AAA_OF_NIB);
                    o_val        = w_ax_add[7:0];
                    o_ah         = w_ax_add[15:8];
                    o_ctl.cf     = 1'b1;
                    o_ctl.af     = 1'b1;
                    o_ctl.zf_val = 1'b1;
                end else if (i_af) begin
                    o_val    = w_ax_add[7:0];
                    o_ah     = w_ax_add[15:8];
                    o_ctl.of = 1'b0;
                    o_ctl.cf = 1'b1;
                    o_ctl.af = 1'b1;
                    o_ctl.zf = 1'b0;
                end else begin
                    o_ctl.of     = 1'b0;
                    o_ctl.cf     = 1'b0;
                    o_ctl.af     = 1'b0;
                    o_ctl.zf_val = 1'b1;
                end
            end
            MODE_AAS: begin
                o_ctl.mask_low = 1'b1;
                o_ctl.pf_val   = 1'b1;
                o_ctl.zf_val   = 1'b1;
                if (w_lo_big) begin
                    o_ctl.sf = (i_al > AAS_SF_LIM);
                    o_val    = w_ax_sub[7:0];
                    o_ah     = w_ax_sub[15:8];
                    o_ctl.of = 1'b0;
                    o_ctl.cf = 1'b1;
                    o_ctl.af = 1'b1;
                end else if (i_af) begin
                    o_ctl.of = i_al[7] & (i_al <= AAS_SF_LIM);
                    o_ctl.sf = (i_al < LO_ADJ) | (i_al > AAS_SF_LIM);
                    o_val    = w_ax_sub[7:0];
                    o_ah     = w_ax_sub[15:8];
                    o_ctl.cf = 1'b1;
                    o_ctl.af = 1'b1;
                end else begin
                    o_ctl.sf = i_al[7];
                    o_ctl.of = 1'b0;
                    o_ctl.cf = 1'b0;
                    o_ctl.af = 1'b0;
                end
            end
            MODE_AAM: begin
                if (i_base == '0) begin
                    o_ctl.de = 1'b1;
                end else begin
                    o_ctl.use_div = 1'b1;
                    o_ctl.cf      = 1'b0;
                    o_ctl.af      = 1'b0;
                    o_ctl.of      = 1'b0;
                    o_ctl.sf_val  = 1'b1;
                    o_ctl.zf_val  = 1'b1;
                    o_ctl.pf_val  = 1'b1;
                end
            end
            MODE_AAD: begin
                o_ctl.use_mul = 1'b1;
                o_ah          = '0;
                o_ctl.cf      = 1'b0;
                o_ctl.af      = 1'b0;
                o_ctl.of      = 1'b0;
                o_ctl.sf_val  = 1'b1;
                o_ctl.zf_val  = 1'b1;
                o_ctl.pf_val  = 1'b1;
            end
            default: begin
                o_ctl.de = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/bau_flags.sv
// ---------------------------------------------------------------------------
// bau_flags
// Last stage logic: evaluates sign, zero and parity of the adjusted low
// byte, merges them with the fixed flags and trims AL for aaa/aas.
// ---------------------------------------------------------------------------
module bau_flags
    import bau_pkg::*;
(
    input  t_ctl       i_ctl,
    input  logic [7:0] i_val,
    output logic [7:0] o_al,
    output t_flags     o_flags
);

    assign o_al = i_ctl.mask_low ? {4'h0, i_val[3:0]} : i_val;

    always_comb begin
        o_flags.cf = i_ctl.cf;
        o_flags.af = i_ctl.af;
        o_flags.of = i_ctl.of;
        o_flags.de = i_ctl.de;
        o_flags.sf = i_ctl.sf_val ? i_val[7] : i_ctl.sf;
        o_flags.zf = i_ctl.zf_val ? (i_val == '0) : i_ctl.zf;
        // parity comes from the value before the nibble trim
        o_flags.pf = i_ctl.pf_val ? ~^i_val : i_ctl.pf;
    end

endmodule

// File: rtl/bcd_adjust_unit.sv
// ---------------------------------------------------------------------------
// bcd_adjust_unit
// Decimal-adjust execution unit for daa, das, aaa, aas, aam and aad.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one instruction word:
//   mode, AL, AH, radix byte and incoming flags. Output channel
//   (o_out_valid / i_out_ready) returns new AL, AH, flags and divide_error.
//   An accepted word passes through stages A, B and C in order and is
//   presented on the outputs from register C; one word is taken per cycle
//   while the receiver does not stall. Three register stages:
//     A: instruction decode, byte adjust, upper four quotient bits of the
//        aam divide, aad multiply.
//     B: lower four quotient bits, aad add, result select.
//     C: sign/zero/parity evaluation into the output register.
//   aam with a zero radix sets divide_error and passes AL, AH and flags.
//   Reset (synchronous, active low) empties all stages. When the receiver
//   stalls, each stage holds its word and only empty stages fill, so
//   o_in_ready drops once all three stages are full.
// ---------------------------------------------------------------------------
module bcd_adjust_unit
    import bau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_al_in,
    input  logic [7:0] i_ah_in,
    input  logic [7:0] i_base,
    input  logic       i_carry_in,
    input  logic       i_aux_in,
    input  logic       i_overflow_in,
    input  logic       i_sign_in,
    input  logic       i_zero_in,
    input  logic       i_parity_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_al_out,
    output logic [7:0] o_ah_out,
    output logic       o_carry_out,
    output logic       o_aux_out,
    output logic       o_sign_out,
    output logic       o_zero_out,
    output logic       o_parity_out,
    output logic       o_overflow_out,
    output logic       o_divide_error
);

    // stage enables
    logic w_en_a;
    logic w_en_b;
    logic w_en_c;

    // stage A
    t_ctl                 w_ctl_a;
    logic [7:0]           w_val_a;
    logic [7:0]           w_ah_a;
    logic [7:0]           w_rem_a;
    logic [DIV_SLICE-1:0] w_quo_a;
    logic [7:0]           w_prod_a;

    logic                 r_a_valid;
    t_ctl                 r_a_ctl;
    logic [7:0]           r_a_val;
    logic [7:0]           r_a_ah;
    logic [7:0]           r_a_rem;
    logic [DIV_SLICE-1:0] r_a_quo;
    logic [7:0]           r_a_base;
    logic [7:0]           r_a_prod;

    // stage B
    logic [7:0]           w_rem_b;
    logic [DIV_SLICE-1:0] w_quo_b;
    logic [7:0]           n_b_val;
    logic [7:0]           n_b_ah;

    logic                 r_b_valid;
    t_ctl                 r_b_ctl;
    logic [7:0]           r_b_val;
    logic [7:0]           r_b_ah;

    // stage C
    logic [7:0]           w_al_c;
    t_flags               w_flags_c;

    logic                 r_c_valid;
    logic [7:0]           r_c_al;
    logic [7:0]           r_c_ah;
    t_flags               r_c_flags;

    assign w_en_c     = ~r_c_valid | i_out_ready;
    assign w_en_b     = ~r_b_valid | w_en_c;
    assign w_en_a     = ~r_a_valid | w_en_b;
    assign o_in_ready = w_en_a;

    bau_decode u_decode (
        .i_mode (i_mode),
        .i_al   (i_al_in),
        .i_ah   (i_ah_in),
        .i_base (i_base),
        .i_cf   (i_carry_in),
        .i_af   (i_aux_in),
        .i_of   (i_overflow_in),
        .i_sf   (i_sign_in),
        .i_zf   (i_zero_in),
        .i_pf   (i_parity_in),
        .o_ctl  (w_ctl_a),
        .o_val  (w_val_a),
        .o_ah   (w_ah_a)
    );

    bau_div_slice u_div_hi (
        .i_rem     (8'h00),
        .i_bits    (i_al_in[7:DIV_SLICE]),
        .i_divisor (i_base),
        .o_rem     (w_rem_a),
        .o_quo     (w_quo_a)
    );

    // only the low byte of the aad product survives
    assign w_prod_a = 8'(i_ah_in * i_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en_a) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_ctl  <= w_ctl_a;
            r_a_val  <= w_val_a;
            r_a_ah   <= w_ah_a;
            r_a_rem  <= w_rem_a;
            r_a_quo  <= w_quo_a;
            r_a_base <= i_base;
            r_a_prod <= w_prod_a;
        end
    end

    bau_div_slice u_div_lo (
        .i_rem     (r_a_rem),
        .i_bits    (r_a_val[DIV_SLICE-1:0]),
        .i_divisor (r_a_base),
        .o_rem     (w_rem_b),
        .o_quo     (w_quo_b)
    );

    always_comb begin
        n_b_val = r_a_val;
        n_b_ah  = r_a_ah;
        if (r_a_ctl.use_div) begin
            n_b_val = w_rem_b;
            n_b_ah  = {r_a_quo, w_quo_b};
        end else if (r_a_ctl.use_mul) begin
            n_b_val = r_a_prod + r_a_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_ctl <= r_a_ctl;
            r_b_val <= n_b_val;
            r_b_ah  <= n_b_ah;
        end
    end

    bau_flags u_flags (
        .i_ctl   (r_b_ctl),
        .i_val   (r_b_val),
        .o_al    (w_al_c),
        .o_flags (w_flags_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_c_al    <= w_al_c;
            r_c_ah    <= r_b_ah;
            r_c_flags <= w_flags_c;
        end
    end

    assign o_out_valid    = r_c_valid;
    assign o_al_out       = r_c_al;
    assign o_ah_out       = r_c_ah;
    assign o_carry_out    = r_c_flags.cf;
    assign o_aux_out      = r_c_flags.af;
    assign o_sign_out     = r_c_flags.sf;
    assign o_zero_out     = r_c_flags.zf;
    assign o_parity_out   = r_c_flags.pf;
    assign o_overflow_out = r_c_flags.of;
    assign o_divide_error = r_c_flags.de;

endmodule
